// ===== sv/cfe_pkg.sv =====
`default_nettype none

package cfe_pkg;

   // block marker geometry
   localparam int MarkerLen = 8;
   localparam int WinIdxW   = $clog2(MarkerLen);
   localparam int FillW     = WinIdxW + 1;
   localparam logic [FillW-1:0] FullFill = FillW'(MarkerLen);

   // marker bytes, oldest byte in the low bits: 1F A6 DE BA CC 13 7D 74
   localparam logic [8*MarkerLen-1:0] BlockMarker = 64'h747D_13CC_BADE_A61F;

   // decoupling queue
   localparam int QueueDepth = 2;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = QPtrW + 1;

   // configuration port
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 14;
   localparam logic [CsrAddrW-1:0] REG_LOW_HALF     = 3'd0;
   localparam logic [CsrAddrW-1:0] REG_HIGH_HALF    = 3'd1;
   localparam logic [CsrAddrW-1:0] REG_SHORT_LEADER = 3'd2;
   localparam logic [CsrAddrW-1:0] REG_LONG_LEADER  = 3'd3;
   localparam logic [CsrAddrW-1:0] REG_GAP_MS       = 3'd4;

   // tone codes
   localparam logic [1:0] TONE_GAP  = 2'd0;
   localparam logic [1:0] TONE_LOW  = 2'd1;
   localparam logic [1:0] TONE_HIGH = 2'd2;

   // segment positions within a block
   localparam logic [3:0] SEG_GAP    = 4'd0;
   localparam logic [3:0] SEG_LEADER = 4'd1;
   localparam logic [3:0] SEG_START  = 4'd2;
   localparam logic [3:0] SEG_DATA0  = 4'd3;
   localparam logic [3:0] SEG_STOP1  = 4'd11;
   localparam logic [3:0] SEG_STOP2  = 4'd12;

   typedef enum logic [1:0] {
      JOB_BYTE,
      JOB_BLOCK_ID,
      JOB_BLOCK_END
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   value;
      logic         win_empty;
   } job_type;

   typedef struct packed {
      logic [9:0]  low_half;
      logic [9:0]  high_half;
      logic [13:0] short_leader;
      logic [13:0] long_leader;
      logic [9:0]  gap_ms;
   } cfg_type;

endpackage

`default_nettype wire

// ===== sv/cfe_ifaces.sv =====
`default_nettype none

interface cfe_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;
   modport source (output valid, output mode, output data_byte, input ready);
   modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface cfe_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  tone;
   logic [9:0]  half_period_us;
   logic [13:0] cycles;
   logic [9:0]  gap_len_ms;
   logic        last;
   logic        window_empty;
   modport source (output valid, output tone, output half_period_us, output cycles,
                   output gap_len_ms, output last, output window_empty, input ready);
   modport sink (input valid, input tone, input half_period_us, input cycles,
                 input gap_len_ms, input last, input window_empty, output ready);
endinterface

interface cfe_csr_if;
   logic                         valid;
   logic                         ready;
   logic [cfe_pkg::CsrAddrW-1:0] addr;
   logic [cfe_pkg::CsrDataW-1:0] wdata;
   modport source (output valid, output addr, output wdata, input ready);
   modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/cfe_front.sv =====
`default_nettype none

module cfe_front (
   input  wire logic       clock,
   input  wire logic       reset,
   cfe_req_if.sink         req,
   output cfe_pkg::job_type job,
   output logic            job_valid,
   input  wire logic       job_ready
);
   import cfe_pkg::*;

   logic [7:0]                win_ff [MarkerLen];
   logic [7:0]                win_in [MarkerLen];
   logic [FillW-1:0]          fill_ff, fill_in;
   logic [8*MarkerLen-1:0]    win_flat;
   logic                      marker_hit;
   logic                      accept;

   assign req.ready = job_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      for (int i = 0; i < MarkerLen; i++) begin
         win_flat[8*i +: 8] = win_ff[i];
      end
   end

   assign marker_hit = (fill_ff == FullFill) && (win_flat == BlockMarker);

   always_comb begin
      win_in    = win_ff;
      fill_in   = fill_ff;
      job_valid = 1'b0;
      job.kind  = JOB_BYTE;
      job.value = win_ff[0];
      if (accept) begin
         if (!req.mode) begin
            if (fill_ff == FullFill) begin
               job_valid = 1'b1;
               if (marker_hit) begin
                  job.kind  = JOB_BLOCK_ID;
                  job.value = req.data_byte;
                  fill_in   = '0;
               end else begin
                  for (int i = 0; i < MarkerLen - 1; i++) begin
                     win_in[i] = win_ff[i+1];
                  end
                  win_in[MarkerLen-1] = req.data_byte;
               end
            end else begin
               win_in[fill_ff[WinIdxW-1:0]] = req.data_byte;
               fill_in = fill_ff + 1'b1;
            end
         end else if (fill_ff != '0) begin
            job_valid = 1'b1;
            if (marker_hit) begin
               job.kind = JOB_BLOCK_END;
               fill_in  = '0;
            end else begin
               for (int i = 0; i < MarkerLen - 1; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               fill_in = fill_ff - 1'b1;
            end
         end
      end
      job.win_empty = (fill_in == '0);
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/cfe_queue.sv =====
`default_nettype none

module cfe_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire cfe_pkg::job_type push_job,
   output logic                  push_ready,
   output logic                  pop_valid,
   output cfe_pkg::job_type      pop_job,
   input  wire logic             pop
);
   import cfe_pkg::*;

   job_type           slot_ff [QueueDepth];
   logic [QPtrW-1:0]  wr_ff, wr_in;
   logic [QPtrW-1:0]  rd_ff, rd_in;
   logic [QCntW-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign push_ready = (cnt_ff != QCntW'(QueueDepth));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_job    = slot_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_in  = do_push ? QPtrW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? QPtrW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/cfe_back.sv =====
`default_nettype none

module cfe_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfe_pkg::cfg_type cfg,
   input  wire logic             job_valid,
   input  wire cfe_pkg::job_type job,
   output logic                  job_pop,
   cfe_rsp_if.source             rsp
);
   import cfe_pkg::*;

   logic [3:0]  cnt_ff, cnt_in;
   logic [3:0]  seg;
   logic [3:0]  bit_ofs;
   logic        seg_last;
   logic        seg_bit;
   logic        fire;

   logic        valid_ff, valid_in;
   logic [1:0]  tone_ff, tone_in;
   logic [9:0]  half_ff, half_in;
   logic [13:0] cyc_ff, cyc_in;
   logic [9:0]  gap_ff, gap_in;
   logic        last_ff;
   logic        empty_ff;

   // byte jobs skip the gap and leader segments
   assign seg      = (job.kind == JOB_BYTE) ? cnt_ff + SEG_START : cnt_ff;
   assign seg_last = ((job.kind == JOB_BLOCK_END) && (seg == SEG_LEADER)) ||
                     (seg == SEG_STOP2);
   assign fire     = job_valid && (!valid_ff || rsp.ready);
   assign job_pop  = fire && seg_last;
   assign bit_ofs  = seg - SEG_DATA0;

   always_comb begin
      if (seg == SEG_START) begin
         seg_bit = 1'b0;
      end else if (seg >= SEG_STOP1) begin
         seg_bit = 1'b1;
      end else begin
         seg_bit = job.value[bit_ofs[2:0]];
      end
   end

   always_comb begin
      tone_in = TONE_GAP;
      half_in = '0;
      cyc_in  = '0;
      gap_in  = '0;
      case (seg)
         SEG_GAP: begin
            gap_in = cfg.gap_ms;
         end
         SEG_LEADER: begin
            tone_in = TONE_HIGH;
            half_in = cfg.high_half;
            cyc_in  = ((job.kind == JOB_BLOCK_ID) && (job.value == '0)) ?
                      cfg.short_leader : cfg.long_leader;
         end
         default: begin
            if (seg_bit) begin
               tone_in = TONE_HIGH;
               half_in = cfg.high_half;
               cyc_in  = 14'd2;
            end else begin
               tone_in = TONE_LOW;
               half_in = cfg.low_half;
               cyc_in  = 14'd1;
            end
         end
      endcase
   end

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      if (fire) begin
         cnt_in   = seg_last ? '0 : cnt_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         tone_ff  <= tone_in;
         half_ff  <= half_in;
         cyc_ff   <= cyc_in;
         gap_ff   <= gap_in;
         last_ff  <= seg_last;
         empty_ff <= job.win_empty;
      end
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.tone           = tone_ff;
   assign rsp.half_period_us = half_ff;
   assign rsp.cycles         = cyc_ff;
   assign rsp.gap_len_ms     = gap_ff;
   assign rsp.last           = last_ff;
   assign rsp.window_empty   = empty_ff;

endmodule

`default_nettype wire

// ===== sv/cassette_fsk_block_encoder.sv =====
// Cassette tape encoder: tape-image bytes go in one per beat, tone segments come out one
// per beat. An ordinary byte becomes eleven segments (start bit, eight data bits lsb first,
// two stop bits); a zero bit is one low-tone cycle, a one bit two high-tone cycles. When the
// eight oldest buffered bytes form the block marker, they are dropped and the block gives a
// silence gap, a leader tone (short when the following id byte is zero, long otherwise) and
// the id byte as data, thirteen segments in all; a flush that finds a bare marker gives just
// the gap and a long leader. Pushes that only fill the window and flushes of an empty window
// give no segments. The output register delivers one segment per clock while the sink
// does not stall; the input side takes a new byte every cycle while the two-entry job
// queue has room and otherwise follows the segment emitter.
// Configuration writes are taken at any time but are meant for idle periods.
`default_nettype none

module cassette_fsk_block_encoder (
   input  wire logic clock,
   input  wire logic reset,
   cfe_req_if.sink   req_chan,
   cfe_rsp_if.source rsp_chan,
   cfe_csr_if.sink   csr_chan
);
   import cfe_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   job_type  front_job;
   logic     front_valid;
   logic     queue_ready;
   job_type  back_job;
   logic     back_valid;
   logic     back_pop;

   // config registers, writes never stall
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.addr)
            REG_LOW_HALF:     cfg_in.low_half     = csr_chan.wdata[9:0];
            REG_HIGH_HALF:    cfg_in.high_half    = csr_chan.wdata[9:0];
            REG_SHORT_LEADER: cfg_in.short_leader = csr_chan.wdata[13:0];
            REG_LONG_LEADER:  cfg_in.long_leader  = csr_chan.wdata[13:0];
            REG_GAP_MS:       cfg_in.gap_ms       = csr_chan.wdata[9:0];
            default:          cfg_in = cfg_ff;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_half     <= 10'd416;
         cfg_ff.high_half    <= 10'd208;
         cfg_ff.short_leader <= 14'd4800;
         cfg_ff.long_leader  <= 14'd12000;
         cfg_ff.gap_ms       <= 10'd500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: lookahead window, marker match; one job per byte that leaves the window, or one block job per marker
   cfe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .job       (front_job),
      .job_valid (front_valid),
      .job_ready (queue_ready)
   );

   // short queue so the window keeps taking bytes while segments drain
   cfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_job   (front_job),
      .push_ready (queue_ready),
      .pop_valid  (back_valid),
      .pop_job    (back_job),
      .pop        (back_pop)
   );

   // back: walks gap, leader and bit segments of the head job into the output register
   cfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (back_valid),
      .job       (back_job),
      .job_pop   (back_pop),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== sv/cfe_checker.sv =====
`default_nettype none

module cfe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_tone,
   input wire logic [9:0]  rsp_half,
   input wire logic [13:0] rsp_cycles,
   input wire logic [9:0]  rsp_gap,
   input wire logic        rsp_last
);
   import cfe_pkg::*;

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tone) && $stable(rsp_cycles)
         && $stable(rsp_last))
      else $error("stalled result beat changed");

   // a gap is always followed by a leader, so it never ends an item
   a_gap_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tone == TONE_GAP) |-> !rsp_last && (rsp_half == '0)
         && (rsp_cycles == '0))
      else $error("malformed gap beat");

   // low tone only carries zero bits, and stop bits close every byte
   a_low_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tone == TONE_LOW) |-> !rsp_last && (rsp_cycles == 14'd1)
         && (rsp_gap == '0))
      else $error("malformed low tone beat");

   // output register is cleared by every reset cycle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind cassette_fsk_block_encoder cfe_checker u_cfe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_tone   (rsp_chan.tone),
   .rsp_half   (rsp_chan.half_period_us),
   .rsp_cycles (rsp_chan.cycles),
   .rsp_gap    (rsp_chan.gap_len_ms),
   .rsp_last   (rsp_chan.last)
);

`default_nettype wire
